@@ sv/stfill_pkg.sv @@
// shared types and constants for the stall timeout frame filler
// used by stfill_engine and stall_timeout_frame_filler_core; no dependencies
package stfill_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int ID_W            = 32;
	localparam int TIME_W          = 32;

	localparam logic [TIME_W-1:0] TOLERANCE_RST = 32'd10000;
	localparam logic [TIME_W-1:0] PERIOD_RST    = 32'd100;

	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_TOLERANCE = 2'd0,
		REG_PERIOD    = 2'd1,
		REG_ALLOW     = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ACT_PASS = 2'd0,
		ACT_DROP = 2'd1,
		ACT_FILL = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WATCH = 2'd1,
		PH_STALL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] tolerance;
		logic [TIME_W-1:0] period;
		logic              allow_delay;
	} cfg_t;

	typedef struct packed {
		action_t         action;
		logic [ID_W-1:0] frame_id;
		logic [ID_W-1:0] channel_id;
	} res_t;

endpackage

@@ sv/stfill_engine.sv @@
// stall detection state and per-item decision logic
// depends on stfill_pkg
module stfill_engine #(
	parameter int COUNT_WIDTH = stfill_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  stfill_pkg::op_t                opcode,
	input  logic [stfill_pkg::ID_W-1:0]    frame_id,
	input  logic [stfill_pkg::ID_W-1:0]    channel_id,
	input  stfill_pkg::cfg_t               cfg,
	output logic                           res_valid,
	output stfill_pkg::res_t               res
);
	import stfill_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] OWED_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [TIME_W-1:0]      TIME_MAX = {TIME_W{1'b1}};

	phase_t                 phase_q, phase_d;
	logic [TIME_W-1:0]      elapsed_q, elapsed_d;
	logic [ID_W-1:0]        last_frame_q, last_frame_d;
	logic [ID_W-1:0]        last_channel_q, last_channel_d;
	logic [COUNT_WIDTH-1:0] owed_q, owed_d;

	logic [TIME_W-1:0] elapsed_inc;
	logic [TIME_W-1:0] period_eff;
	logic              drop;
	logic              fill;

	// saturating tick count while stalled, zero period behaves as one
	assign elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign period_eff  = (cfg.period == '0) ? TIME_W'(1) : cfg.period;
	assign drop        = !cfg.allow_delay && (owed_q != '0);
	assign fill        = (phase_q == PH_STALL) && (elapsed_inc >= period_eff);

	// next state
	always_comb begin
		phase_d        = phase_q;
		elapsed_d      = elapsed_q;
		last_frame_d   = last_frame_q;
		last_channel_d = last_channel_q;
		owed_d         = owed_q;
		if (item_valid) begin
			if (opcode == OP_FRAME) begin
				phase_d        = PH_WATCH;
				elapsed_d      = '0;
				last_frame_d   = frame_id;
				last_channel_d = channel_id;
				if (drop) begin
					owed_d = owed_q - 1'b1;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_WATCH: begin
						if (elapsed_q >= cfg.tolerance) begin
							phase_d   = PH_STALL;
							elapsed_d = '0;
						end else begin
							elapsed_d = elapsed_q + 1'b1;
						end
					end
					PH_STALL: begin
						if (fill) begin
							elapsed_d    = '0;
							last_frame_d = last_frame_q + 1'b1;
							if (owed_q != OWED_MAX) begin
								owed_d = owed_q + 1'b1;
							end
						end else begin
							elapsed_d = elapsed_inc;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// result of the current item
	always_comb begin
		res_valid      = 1'b0;
		res.action     = ACT_PASS;
		res.frame_id   = frame_id;
		res.channel_id = channel_id;
		if (item_valid) begin
			if (opcode == OP_FRAME) begin
				res_valid  = 1'b1;
				res.action = drop ? ACT_DROP : ACT_PASS;
			end else if (fill) begin
				res_valid      = 1'b1;
				res.action     = ACT_FILL;
				res.frame_id   = last_frame_q + 1'b1;
				res.channel_id = last_channel_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			elapsed_q      <= '0;
			last_frame_q   <= '0;
			last_channel_q <= '0;
			owed_q         <= '0;
		end else begin
			phase_q        <= phase_d;
			elapsed_q      <= elapsed_d;
			last_frame_q   <= last_frame_d;
			last_channel_q <= last_channel_d;
			owed_q         <= owed_d;
		end
	end

	a_fill_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.action == ACT_FILL) |-> (phase_q == PH_STALL && opcode == OP_TICK))
		else $error("filler issued outside a stall");

	a_drop_needs_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && opcode == OP_FRAME && drop) |=> (owed_q == $past(owed_q) - 1'b1))
		else $error("owed count not paid back on drop");

	a_frame_resets_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && opcode == OP_FRAME) |=> (phase_q == PH_WATCH && elapsed_q == '0))
		else $error("frame arrival did not restart the timer");

endmodule

@@ sv/stall_timeout_frame_filler_core.sv @@
// top level of the stall timeout frame filler: stream ports, register file, output skid
// depends on stfill_pkg and stfill_engine
//
// each result is registered in the output register, or first parked in the skid entry while the output is held
// throughput: one input transfer per cycle; input stalls only when both output slots are full
// the decision for each item is made in a single pass of stfill_engine at the input transfer
// reset: arst_n clears phase to idle, timer, ids and owed count to zero, registers to defaults
// output register plus one skid entry keep input flowing while a result waits
module stall_timeout_frame_filler_core #(
	parameter int COUNT_WIDTH = stfill_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] frame_id, [63:32] channel_id
	input  logic        s_tuser,   // [0] opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] out_frame_id, [63:32] out_channel_id
	output logic [1:0]  m_tuser,   // [1:0] action
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import stfill_pkg::*;

	// register file
	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance   <= TOLERANCE_RST;
			cfg_q.period      <= PERIOD_RST;
			cfg_q.allow_delay <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TOLERANCE: cfg_q.tolerance   <= pwdata;
				REG_PERIOD:    cfg_q.period      <= pwdata;
				REG_ALLOW:     cfg_q.allow_delay <= pwdata[0];
				default: begin
					// unmapped address, write ignored
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TOLERANCE: prdata = cfg_q.tolerance;
			REG_PERIOD:    prdata = cfg_q.period;
			REG_ALLOW:     prdata = {31'd0, cfg_q.allow_delay};
			default:       prdata = '0;
		endcase
	end

	// decision logic, runs on every input transfer
	logic in_xfer;
	logic res_valid;
	res_t res;

	assign in_xfer = s_tvalid && s_tready;

	stfill_engine #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_xfer),
		.opcode     (op_t'(s_tuser)),
		.frame_id   (s_tdata[31:0]),
		.channel_id (s_tdata[63:32]),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register and skid entry
	logic out_valid_q, out_valid_d;
	logic skid_valid_q, skid_valid_d;
	res_t out_q, out_d;
	res_t skid_q, skid_d;
	logic out_xfer;

	assign out_xfer = out_valid_q && m_tready;
	// the skid entry only fills when the output register is stuck, so one free slot suffices
	assign s_tready = !skid_valid_q;

	always_comb begin
		out_valid_d  = out_valid_q;
		skid_valid_d = skid_valid_q;
		out_d        = out_q;
		skid_d       = skid_q;
		if (!out_valid_q || out_xfer) begin
			// output slot free this cycle: older skid result goes first
			if (skid_valid_q) begin
				out_d        = skid_q;
				out_valid_d  = 1'b1;
				skid_valid_d = 1'b0;
			end else if (res_valid) begin
				out_d       = res;
				out_valid_d = 1'b1;
			end else begin
				out_valid_d = 1'b0;
			end
		end else if (res_valid) begin
			// output held by downstream, park the new result
			skid_d       = res;
			skid_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= out_valid_d;
			skid_valid_q <= skid_valid_d;
		end
	end

	// payload registers need no reset
	always_ff @(posedge clk) begin
		out_q  <= out_d;
		skid_q <= skid_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.channel_id, out_q.frame_id};
	assign m_tuser  = out_q.action;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while output register is empty");

	a_park_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && res_valid) |=> skid_valid_q)
		else $error("result lost while output stalled");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_tready) |=> (out_valid_q && out_q == $past(skid_q)))
		else $error("skid result not moved to output register");

	a_action_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ACT_PASS || m_tuser == ACT_DROP || m_tuser == ACT_FILL))
		else $error("illegal action code on output");

endmodule

@@ bench/tb.sv @@
// self-checking bench for stall_timeout_frame_filler_core: directed and random event streams
// with randomized stream idling and a built-in model of the stall and filler decisions
// depends on stfill_pkg and stall_timeout_frame_filler_core
`timescale 1ns / 1ps

module tb;
	import stfill_pkg::*;

	localparam int OWED_W      = COUNT_WIDTH_DEF;
	localparam int QUIET_LIMIT = 3000;  // cycles with no transfer before the run is abandoned
	localparam int HOLD_CYCLES = 400;   // length of the long receiver hold-off
	localparam int SETTLE_GAP  = 4;     // extra wait after the last due result, leaves some margin

	// one input event as the bench queues it
	typedef struct packed {
		op_t        op;
		logic [31:0] fid;
		logic [31:0] cid;
	} frame_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;     // [31:0] frame_id, [63:32] channel_id
	logic        s_tuser = 1'b0;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // [31:0] out_frame_id, [63:32] out_channel_id
	logic [1:0]  m_tuser;          // [1:0] action
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	stall_timeout_frame_filler_core #(.COUNT_WIDTH(OWED_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// events waiting to be offered and verdicts waiting to come out
	frame_event_t event_q[$];
	res_t         verdict_q[$];

	// bench copy of the block's registers and state
	cfg_t                cfg = '{tolerance: TOLERANCE_RST, period: PERIOD_RST, allow_delay: 1'b0};
	phase_t              watch_phase = PH_IDLE;
	logic [TIME_W-1:0]   ticks_since = '0;
	logic [ID_W-1:0]     last_fid = '0;
	logic [ID_W-1:0]     last_cid = '0;
	logic [OWED_W-1:0]   owed = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int fails = 0;

	function automatic res_t make_verdict(action_t act, logic [ID_W-1:0] fid, logic [ID_W-1:0] cid);
		res_t v;
		v.action = act;
		v.frame_id = fid;
		v.channel_id = cid;
		return v;
	endfunction

	// decides what one accepted event produces; returns 1 when a result is due
	function automatic bit frame_verdict(input op_t op, input logic [ID_W-1:0] fid,
			input logic [ID_W-1:0] cid, output res_t v);
		logic [TIME_W-1:0] per;
		v = '0;
		// a zero period behaves like one filler per tick
		per = (cfg.period == '0) ? TIME_W'(1) : cfg.period;
		if (op == OP_FRAME) begin
			// every arrival restarts the timer and becomes the new filler base
			last_fid = fid;
			last_cid = cid;
			watch_phase = PH_WATCH;
			ticks_since = '0;
			if (!cfg.allow_delay && owed != '0) begin
				owed = owed - 1'b1;
				v = make_verdict(ACT_DROP, fid, cid);
			end else begin
				v = make_verdict(ACT_PASS, fid, cid);
			end
			return 1'b1;
		end
		case (watch_phase)
			PH_WATCH: begin
				// the tick that finds the timer at the tolerance opens the stall silently
				if (ticks_since >= cfg.tolerance) begin
					watch_phase = PH_STALL;
					ticks_since = '0;
				end else begin
					ticks_since = ticks_since + 1'b1;
				end
			end
			PH_STALL: begin
				if (ticks_since != '1)
					ticks_since = ticks_since + 1'b1;
				if (ticks_since >= per) begin
					ticks_since = '0;
					last_fid = last_fid + 1'b1;   // wraps through zero
					if (owed != '1)
						owed = owed + 1'b1;       // saturates
					v = make_verdict(ACT_FILL, last_fid, last_cid);
					return 1'b1;
				end
			end
			default: ;  // ticks before the first frame are ignored
		endcase
		return 1'b0;
	endfunction

	// input driver: predicts on each transfer, then offers the next queued event
	always @(posedge clk) begin : drive_input
		res_t         v;
		frame_event_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (frame_verdict(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32], v))
					verdict_q.push_back(v);
			end
			if (!s_tvalid || s_tready) begin
				if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = event_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {nxt.cid, nxt.fid};
					s_tuser <= nxt.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver backpressure
	always @(posedge clk) begin : watch_output
		int   hold_left;
		int   hold_seen;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t: result with none due: action %0d frame %h channel %h",
						$realtime, m_tuser, m_tdata[31:0], m_tdata[63:32]);
			end else begin
				want = verdict_q.pop_front();
				if (m_tuser !== want.action || m_tdata[31:0] !== want.frame_id ||
						m_tdata[63:32] !== want.channel_id) begin
					fails++;
					if (fails <= 10)
						$display("%0t: mismatch: expected action %0d frame %h channel %h, got action %0d frame %h channel %h",
							$realtime, want.action, want.frame_id, want.channel_id,
							m_tuser, m_tdata[31:0], m_tdata[63:32]);
				end
			end
		end
		// a long hold-off is requested by bumping hold_reqs and timed here
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: gives up after a long stretch with no transfer on any port
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic queue_event(op_t op, logic [31:0] fid, logic [31:0] cid);
		frame_event_t e;
		e.op = op;
		e.fid = fid;
		e.cid = cid;
		event_q.push_back(e);
	endtask

	// ids lean on the extremes now and then
	function automatic logic [31:0] pick_id();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// register write: setup then access, lands at the edge with penable high
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TOLERANCE: cfg.tolerance = val;
			REG_PERIOD:    cfg.period = val;
			REG_ALLOW:     cfg.allow_delay = val[0];
			default: ;
		endcase
	endtask

	// waits until every queued event went in and every due result came out
	task automatic drain();
		while (event_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	task automatic set_regs(logic [31:0] tol, logic [31:0] per, bit allow);
		drain();
		reg_write(REG_TOLERANCE, tol);
		reg_write(REG_PERIOD, per);
		reg_write(REG_ALLOW, {31'b0, allow});
		@(negedge clk);
	endtask

	// one well-formed stretch: a frame, a tick run of random length up to 40 that may reach fillers,
	// sometimes a burst of frames that pays fillers back, sometimes a stray event
	task automatic queue_stretch(logic [31:0] tol, logic [31:0] per, inout int count);
		longint reach;
		int     n;
		queue_event(OP_FRAME, pick_id(), pick_id());
		count++;
		reach = longint'(tol) + 3 * longint'(per) + 3;
		if (reach > 40)
			reach = 40;
		n = $urandom_range(0, int'(reach));
		repeat (n) queue_event(OP_TICK, $urandom, $urandom);
		count += n;
		if ($urandom_range(3) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) queue_event(OP_FRAME, pick_id(), pick_id());
			count += n;
		end
		if ($urandom_range(9) == 0) begin
			queue_event(op_t'($urandom_range(1)), $urandom, $urandom);
			count++;
		end
	endtask

	task automatic random_phase(logic [31:0] tol, logic [31:0] per, bit allow,
			int idle_pct, int stall_pct, int items, bit long_hold);
		int count;
		count = 0;
		set_regs(tol, per, allow);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (count < items)
			queue_stretch(tol, per, count);
		// receiver stops for a long while as the sender keeps offering
		if (long_hold)
			hold_reqs++;
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: ticks before any frame are ignored, then a frame and
		// a few ticks far below the default tolerance
		queue_event(OP_TICK, 32'hffff_ffff, 32'hffff_ffff);
		queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_FRAME, 32'h1234_5678, 32'ha5a5_a5a5);
		queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_TICK, 32'h0, 32'h0);

		// zero tolerance and zero period: stall on the first tick, then one filler per
		// tick, filler id wraps from the all-ones frame id
		set_regs(32'h0, 32'h0, 1'b0);
		queue_event(OP_FRAME, 32'hffff_ffff, 32'hffff_ffff);
		queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_FRAME, 32'h0, 32'h0);           // dropped, owed two
		queue_event(OP_FRAME, 32'h5, 32'h6);           // dropped, owed one
		queue_event(OP_FRAME, 32'h7, 32'h8);           // passes
		queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_TICK, 32'h0, 32'h0);

		// delay allowed: owed fillers pile up but frames still pass
		set_regs(32'h1, 32'h2, 1'b1);
		queue_event(OP_FRAME, 32'h1, 32'h1);
		repeat (4) queue_event(OP_TICK, 32'h0, 32'h0);
		queue_event(OP_FRAME, 32'h10, 32'h20);

		// delay forbidden again: the kept owed count is paid back
		set_regs(32'h1, 32'h2, 1'b0);
		queue_event(OP_FRAME, 32'h30, 32'h40);
		queue_event(OP_FRAME, 32'h50, 32'h60);
		queue_event(OP_FRAME, 32'h70, 32'h80);

		// random part, idling modes rotate across phases
		random_phase(32'd3, 32'd2, 1'b0, 0, 0, 200, 1'b0);
		random_phase(32'd0, 32'd1, 1'b1, 54, 0, 200, 1'b0);
		random_phase(32'd5, 32'd4, 1'b0, 0, 54, 200, 1'b1);
		random_phase(32'd1, 32'd0, 1'b0, 8, 8, 200, 1'b0);
		random_phase(32'd7, 32'd3, 1'b1, 0, 0, 200, 1'b0);
		random_phase(32'd2, 32'd5, 1'b0, 54, 0, 200, 1'b0);
		random_phase(32'hffff_ffff, 32'hffff_ffff, 1'b0, 0, 54, 50, 1'b0);
		random_phase(32'd4, 32'd1, 1'b0, 8, 8, 200, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (verdict_q.size() != 0) begin
			fails++;
			$display("%0d results never arrived", verdict_q.size());
		end
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ stall_timeout_frame_filler_core.f @@
sv/stfill_pkg.sv
sv/stfill_engine.sv
sv/stall_timeout_frame_filler_core.sv
bench/tb.sv
